### hw/rtl/pcrq_pkg.sv
// ----------------------------------------------------------------------------
// pcrq_pkg
// Shared types, field widths and codes for the per-CPU priority run queue.
// ----------------------------------------------------------------------------
package pcrq_pkg;

   localparam int NUM_CPUS_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_TASKS_DEF   = 64;

   localparam int CMD_W    = 2;
   localparam int CPU_W    = 3;
   localparam int TASK_W   = 6;
   localparam int PRIO_W   = 8;
   localparam int AFF_W    = 4;
   localparam int STATUS_W = 2;
   localparam int STEAL_W  = 32;
   localparam int CFG_W    = 4;
   localparam int RR_W     = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ  = 2'd0,
      CMD_RMV  = 2'd1,
      CMD_PICK = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_REJECT   = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [TASK_W-1:0]        task_id;
      logic [PRIO_W-1:0]        prio;
      logic signed [AFF_W-1:0]  aff;
   } slot_type;

   typedef struct packed {
      logic slot_we;
      logic home_we;
   } store_ctl_type;

   // which flow a shared insert or remove routine returns to
   typedef enum logic [1:0] {
      CTX_ENQ,
      CTX_RMV,
      CTX_LOCAL,
      CTX_STEAL
   } ctx_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_RMV_HOME,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_RM_RD,
      S_RM_GET,
      S_RM_SH,
      S_RM_WR,
      S_LOCAL,
      S_LFIT,
      S_SFIT,
      S_HOME,
      S_HOME_WAIT,
      S_INS_CHK,
      S_INS_RD,
      S_INS_CMP,
      S_INS_PUT,
      S_STEAL_INIT,
      S_STEAL_WAIT,
      S_STEAL,
      S_SNEXT,
      S_DONE
   } state_type;

endpackage

### hw/rtl/pcrq_if.sv
// ----------------------------------------------------------------------------
// pcrq_if
// Request and response channels of the run queue (valid/ready handshake).
// ----------------------------------------------------------------------------
interface pcrq_req_if import pcrq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [CPU_W-1:0]         cpu;
   logic [TASK_W-1:0]        task_id;
   logic [PRIO_W-1:0]        priority_req;
   logic signed [AFF_W-1:0]  affinity;

   modport source(output valid, cmd, cpu, task_id, priority_req, affinity, input ready);
   modport sink(input valid, cmd, cpu, task_id, priority_req, affinity, output ready);
endinterface

interface pcrq_rsp_if import pcrq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [TASK_W-1:0]    picked_task;
   logic                 found;
   logic                 was_stolen;
   logic [STEAL_W-1:0]   steal_count;

   modport source(output valid, status, picked_task, found, was_stolen, steal_count,
                  input ready);
   modport sink(input valid, status, picked_task, found, was_stolen, steal_count,
                output ready);
endinterface

### hw/rtl/pcrq_mod.sv
// ----------------------------------------------------------------------------
// pcrq_mod
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor.
// ----------------------------------------------------------------------------
module pcrq_mod import pcrq_pkg::*; #(
   parameter int DIV_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RR_W-1:0]  dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] rem,
   output logic             done
);

   localparam int CNT_W = $clog2(RR_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RR_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   shifted;

   // one quotient bit a cycle: shift in next dividend bit, subtract if it fits
   assign shifted = {rem_ff, dvd_ff[RR_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RR_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            rem_in = DIV_W'(shifted - {1'b0, divisor});
         end else begin
            rem_in = DIV_W'(shifted);
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(RR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

### hw/rtl/pcrq_store.sv
// ----------------------------------------------------------------------------
// pcrq_store
// Slot memory of all run queues and per-task home memory, registered reads.
// ----------------------------------------------------------------------------
module pcrq_store import pcrq_pkg::*; #(
   parameter int SLOTS     = 128,
   parameter int NUM_TASKS = 64,
   parameter int CW        = 3
) (
   input  logic                         clock,
   input  store_ctl_type                ctl,
   input  logic [$clog2(SLOTS)-1:0]     slot_waddr,
   input  slot_type                     slot_wdata,
   input  logic [$clog2(SLOTS)-1:0]     slot_raddr,
   output slot_type                     slot_rdata,
   input  logic [$clog2(NUM_TASKS)-1:0] home_waddr,
   input  logic [CW-1:0]                home_wdata,
   input  logic [$clog2(NUM_TASKS)-1:0] home_raddr,
   output logic [CW-1:0]                home_rdata
);

   slot_type    slot_mem [SLOTS];
   logic [CW-1:0] home_mem [NUM_TASKS];

   always_ff @(posedge clock) begin
      if (ctl.slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.home_we) begin
         home_mem[home_waddr] <= home_wdata;
      end
      home_rdata <= home_mem[home_raddr];
   end

endmodule

### hw/rtl/per_cpu_priority_runqueue_steal.sv
// ----------------------------------------------------------------------------
// per_cpu_priority_runqueue_steal
// Per-CPU priority run queues with enqueue, remove and pick-next with stealing.
// ----------------------------------------------------------------------------
// Usage:
//  req_if carries one command per transaction: enqueue (cpu, task_id,
//  priority_req, affinity), remove (task_id) or pick next (cpu). rsp_if
//  returns exactly one transaction per request with status, picked_task,
//  found, was_stolen and the running steal_count.
//  csr_we/csr_wdata write cpu_count (CPUs in use); write it only while idle.
//  Operation: the slot memory takes one slot read and one slot write per
//  cycle, so a command walks its queue one entry at a time. Enqueue steps
//  through each entry that it shifts, and a rejected one stops at the check;
//  remove steps to the position of the task and then through the entries
//  after it; a pick adds each re-home (insert plus a round robin remainder
//  step) and a remainder step to start the steal scan. One command is
//  worked at a time.
//  The next request is accepted while a finished response still waits:
//  the response sits in an output register, and only the final step of the
//  following command holds until the receiver takes it.
//  Reset (synchronous): queues empty, no task queued, counters zero,
//  cpu_count 1. The slot and home memories need no clearing pass: an entry
//  is only read after it was written.
// ----------------------------------------------------------------------------
module per_cpu_priority_runqueue_steal import pcrq_pkg::*; #(
   parameter int NUM_CPUS    = NUM_CPUS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int NUM_TASKS   = NUM_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata,
   pcrq_req_if.sink          req_if,
   pcrq_rsp_if.source        rsp_if
);

   localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CPW   = $clog2(NUM_CPUS + 1);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TW    = $clog2(NUM_TASKS);
   localparam int SLOTS = NUM_CPUS * QUEUE_DEPTH;
   localparam int AW    = $clog2(SLOTS);
   localparam int MW    = (CPW > 1) ? CPW : 2;

   function automatic logic [AW-1:0] slot_addr(logic [CW-1:0] c, logic [CNT_W-1:0] p);
      return AW'(int'(c) * QUEUE_DEPTH + int'(p));
   endfunction

   // control and state
   state_type           state_ff, state_in;
   ctx_type             ctx_ff, ctx_in;
   logic [CNT_W-1:0]    counts_ff [NUM_CPUS];
   logic [CNT_W-1:0]    counts_in [NUM_CPUS];
   logic [NUM_TASKS-1:0] queued_ff, queued_in;
   logic [RR_W-1:0]     rr_ff, rr_in;
   logic [STEAL_W-1:0]  steals_ff, steals_in;
   logic [CFG_W-1:0]    cfg_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // request and work registers
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [CPU_W-1:0]        cpu_ff, cpu_in;
   logic [TASK_W-1:0]       task_ff, task_in;
   logic [PRIO_W-1:0]       prio_ff, prio_in;
   logic signed [AFF_W-1:0] aff_ff, aff_in;
   slot_type                s_ff, s_in;
   logic [CW-1:0]           tgt_ff, tgt_in;
   logic [CW-1:0]           vic_ff, vic_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CPW-1:0]          v_ff, v_in;
   status_type              status_ff, status_in;
   logic [TASK_W-1:0]       picked_ff, picked_in;
   logic                    found_ff, found_in;
   logic                    stolen_ff, stolen_in;

   // response register
   status_type              rsp_status_ff, rsp_status_in;
   logic [TASK_W-1:0]       rsp_picked_ff, rsp_picked_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_stolen_ff, rsp_stolen_in;
   logic [STEAL_W-1:0]      rsp_steals_ff, rsp_steals_in;

   // memory and remainder unit
   store_ctl_type   st_ctl;
   logic [AW-1:0]   slot_waddr, slot_raddr;
   slot_type        slot_wdata, slot_rdata;
   logic [CW-1:0]   home_rdata;
   logic            mod_start, mod_done;
   logic [RR_W-1:0] mod_dividend;
   logic [MW-1:0]   mod_rem;

   // shared decode
   logic [CPW-1:0]   cpus;
   logic [CW-1:0]    cpu_idx, cidx;
   logic [CNT_W-1:0] cnt;
   logic             cpu_ok, task_ok, fit, aff_home_ok, ins_ok;
   logic [RR_W-1:0]  rr_mag;
   logic [CW-1:0]    vic_next;
   state_type        ret_ins, ret_rm;

   // clamp CPUs in use to 1..NUM_CPUS
   always_comb begin
      if (cfg_ff == '0) begin
         cpus = CPW'(1);
      end else if (int'(cfg_ff) > NUM_CPUS) begin
         cpus = CPW'(NUM_CPUS);
      end else begin
         cpus = CPW'(cfg_ff);
      end
   end

   assign cpu_idx = CW'(cpu_ff);
   assign cpu_ok  = int'(cpu_ff) < NUM_CPUS;
   assign task_ok = int'(task_ff) < NUM_TASKS;

   // one read port into the count registers, steered by the state
   always_comb begin
      case (state_ff)
         S_DISPATCH, S_LOCAL: cidx = cpu_idx;
         S_STEAL:             cidx = vic_ff;
         default:             cidx = tgt_ff;
      endcase
   end
   assign cnt = counts_ff[cidx];

   assign fit         = s_ff.aff[AFF_W-1] || (int'(s_ff.aff) == int'(cpu_ff));
   assign aff_home_ok = !s_ff.aff[AFF_W-1] && (int'(s_ff.aff) < int'(cpus));
   assign ins_ok      = (int'(s_ff.task_id) < NUM_TASKS) &&
                        !queued_ff[TW'(s_ff.task_id)] && (int'(cnt) < QUEUE_DEPTH);
   assign rr_mag      = rr_ff[RR_W-1] ? (~rr_ff + RR_W'(1)) : rr_ff;
   assign vic_next    = (int'(vic_ff) + 1 == int'(cpus)) ? '0 : vic_ff + CW'(1);

   // where the shared insert and remove routines hand back control
   always_comb begin
      case (ctx_ff)
         CTX_LOCAL: ret_ins = S_LOCAL;
         CTX_STEAL: ret_ins = S_SNEXT;
         default:   ret_ins = S_DONE;
      endcase
      case (ctx_ff)
         CTX_LOCAL: ret_rm = S_LFIT;
         CTX_STEAL: ret_rm = S_SFIT;
         default:   ret_rm = S_DONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_ENQ:  state_in = cpu_ok ? S_INS_CHK : S_DONE;
               CMD_RMV:  state_in = (task_ok && queued_ff[TW'(task_ff)]) ? S_RMV_HOME : S_DONE;
               CMD_PICK: state_in = cpu_ok ? S_LOCAL : S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_RMV_HOME:   state_in = S_SRCH_RD;
         S_SRCH_RD:    state_in = (idx_ff < cnt) ? S_SRCH_CMP : S_DONE;
         S_SRCH_CMP:   state_in = (slot_rdata.task_id == task_ff) ? S_RM_RD : S_SRCH_RD;
         S_RM_RD:      state_in = S_RM_GET;
         S_RM_GET:     state_in = S_RM_SH;
         S_RM_SH:      state_in = (idx_ff < cnt) ? S_RM_WR : ret_rm;
         S_RM_WR:      state_in = S_RM_SH;
         S_LOCAL:      state_in = (k_ff < n_ff && cnt != '0) ? S_RM_RD : S_STEAL_INIT;
         S_LFIT:       state_in = fit ? S_DONE : S_HOME;
         S_SFIT:       state_in = fit ? S_DONE : S_HOME;
         S_HOME:       state_in = aff_home_ok ? S_INS_CHK : S_HOME_WAIT;
         S_HOME_WAIT:  state_in = mod_done ? S_INS_CHK : S_HOME_WAIT;
         S_INS_CHK:    state_in = ins_ok ? S_INS_RD : ret_ins;
         S_INS_RD:     state_in = (pos_ff == '0) ? S_INS_PUT : S_INS_CMP;
         S_INS_CMP:    state_in = (slot_rdata.prio < s_ff.prio) ? S_INS_RD : S_INS_PUT;
         S_INS_PUT:    state_in = ret_ins;
         S_STEAL_INIT: state_in = (cpus > CPW'(1)) ? S_STEAL_WAIT : S_DONE;
         S_STEAL_WAIT: state_in = mod_done ? S_STEAL : S_STEAL_WAIT;
         S_STEAL: begin
            if (v_ff < cpus) begin
               state_in = (cnt == '0) ? S_STEAL : S_RM_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SNEXT:      state_in = S_STEAL;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) state_in = S_IDLE;
         end
         default:      state_in = S_IDLE;
      endcase
   end

   // datapath, memory and counter updates
   always_comb begin
      ctx_in    = ctx_ff;
      counts_in = counts_ff;
      queued_in = queued_ff;
      rr_in     = rr_ff;
      steals_in = steals_ff;
      cmd_in    = cmd_ff;
      cpu_in    = cpu_ff;
      task_in   = task_ff;
      prio_in   = prio_ff;
      aff_in    = aff_ff;
      s_in      = s_ff;
      tgt_in    = tgt_ff;
      vic_in    = vic_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      v_in      = v_ff;
      status_in = status_ff;
      picked_in = picked_ff;
      found_in  = found_ff;
      stolen_in = stolen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_picked_in = rsp_picked_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_steals_in = rsp_steals_ff;
      st_ctl        = '0;
      slot_waddr    = slot_addr(tgt_ff, pos_ff);
      slot_wdata    = s_ff;
      slot_raddr    = slot_addr(tgt_ff, idx_ff);
      mod_start     = 1'b0;
      mod_dividend  = rr_mag;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in    = req_if.cmd;
               cpu_in    = req_if.cpu;
               task_in   = req_if.task_id;
               prio_in   = req_if.priority_req;
               aff_in    = req_if.affinity;
               picked_in = '0;
               found_in  = 1'b0;
               stolen_in = 1'b0;
            end
         end
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_ENQ: begin
                  if (cpu_ok) begin
                     s_in   = '{task_id: task_ff, prio: prio_ff, aff: aff_ff};
                     tgt_in = cpu_idx;
                     ctx_in = CTX_ENQ;
                  end else begin
                     status_in = ST_REJECT;
                  end
               end
               CMD_RMV: begin
                  if (task_ok && queued_ff[TW'(task_ff)]) begin
                     ctx_in = CTX_RMV;
                     idx_in = '0;
                  end else begin
                     status_in = ST_NOTFOUND;
                  end
               end
               CMD_PICK: begin
                  if (cpu_ok) begin
                     n_in = cnt;
                     k_in = '0;
                  end else begin
                     status_in = ST_NOTFOUND;
                  end
               end
               default: status_in = ST_REJECT;
            endcase
         end
         S_RMV_HOME: tgt_in = home_rdata;
         S_SRCH_RD: begin
            // a queued task always sits in its home queue; miss is a guard only
            if (!(idx_ff < cnt)) begin
               status_in = ST_NOTFOUND;
               queued_in[TW'(task_ff)] = 1'b0;
            end
         end
         S_SRCH_CMP: begin
            if (slot_rdata.task_id == task_ff) begin
               pos_in = idx_ff;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_RM_RD: slot_raddr = slot_addr(tgt_ff, pos_ff);
         S_RM_GET: begin
            s_in   = slot_rdata;
            idx_in = pos_ff + CNT_W'(1);
         end
         S_RM_SH: begin
            if (!(idx_ff < cnt)) begin
               counts_in[tgt_ff] = cnt - CNT_W'(1);
               queued_in[TW'(s_ff.task_id)] = 1'b0;
               if (ctx_ff == CTX_RMV) status_in = ST_DONE;
            end
         end
         S_RM_WR: begin
            // close the gap: move entry idx down by one
            st_ctl.slot_we = 1'b1;
            slot_waddr     = slot_addr(tgt_ff, idx_ff - CNT_W'(1));
            slot_wdata     = slot_rdata;
            idx_in         = idx_ff + CNT_W'(1);
         end
         S_LOCAL: begin
            if (k_ff < n_ff && cnt != '0) begin
               tgt_in = cpu_idx;
               pos_in = '0;
               ctx_in = CTX_LOCAL;
               k_in   = k_ff + CNT_W'(1);
            end
         end
         S_LFIT: begin
            if (fit) begin
               picked_in = s_ff.task_id;
               found_in  = 1'b1;
               status_in = ST_DONE;
            end
         end
         S_SFIT: begin
            if (fit) begin
               picked_in = s_ff.task_id;
               found_in  = 1'b1;
               stolen_in = 1'b1;
               steals_in = steals_ff + STEAL_W'(1);
               status_in = ST_DONE;
            end
         end
         S_HOME: begin
            if (aff_home_ok) begin
               tgt_in = CW'($unsigned(s_ff.aff));
            end else begin
               mod_start = 1'b1;
               rr_in     = rr_ff + RR_W'(1);
            end
         end
         S_HOME_WAIT: begin
            if (mod_done) tgt_in = CW'(mod_rem);
         end
         S_INS_CHK: begin
            if (ins_ok) begin
               pos_in = cnt;
            end else if (ctx_ff == CTX_ENQ) begin
               status_in = ST_REJECT;
            end
         end
         S_INS_RD: slot_raddr = slot_addr(tgt_ff, pos_ff - CNT_W'(1));
         S_INS_CMP: begin
            // lower priority entry moves up one place
            if (slot_rdata.prio < s_ff.prio) begin
               st_ctl.slot_we = 1'b1;
               slot_wdata     = slot_rdata;
               pos_in         = pos_ff - CNT_W'(1);
            end
         end
         S_INS_PUT: begin
            st_ctl.slot_we = 1'b1;
            st_ctl.home_we = 1'b1;
            counts_in[tgt_ff] = cnt + CNT_W'(1);
            queued_in[TW'(s_ff.task_id)] = 1'b1;
            if (ctx_ff == CTX_ENQ) status_in = ST_DONE;
         end
         S_STEAL_INIT: begin
            if (cpus > CPW'(1)) begin
               mod_start    = 1'b1;
               mod_dividend = RR_W'(cpu_ff) + RR_W'(1);
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         S_STEAL_WAIT: begin
            if (mod_done) begin
               vic_in = CW'(mod_rem);
               v_in   = CPW'(1);
            end
         end
         S_STEAL: begin
            if (v_ff < cpus) begin
               if (cnt == '0) begin
                  v_in   = v_ff + CPW'(1);
                  vic_in = vic_next;
               end else begin
                  tgt_in = vic_ff;
                  pos_in = cnt - CNT_W'(1);
                  ctx_in = CTX_STEAL;
               end
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         S_SNEXT: begin
            v_in   = v_ff + CPW'(1);
            vic_in = vic_next;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_picked_in = picked_ff;
               rsp_found_in  = found_ff;
               rsp_stolen_in = stolen_ff;
               rsp_steals_in = steals_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counts_ff    <= '{default: '0};
         queued_ff    <= '0;
         rr_ff        <= '0;
         steals_ff    <= '0;
         cfg_ff       <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         queued_ff    <= queued_in;
         rr_ff        <= rr_in;
         steals_ff    <= steals_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff        <= ctx_in;
      cmd_ff        <= cmd_in;
      cpu_ff        <= cpu_in;
      task_ff       <= task_in;
      prio_ff       <= prio_in;
      aff_ff        <= aff_in;
      s_ff          <= s_in;
      tgt_ff        <= tgt_in;
      vic_ff        <= vic_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      v_ff          <= v_in;
      status_ff     <= status_in;
      picked_ff     <= picked_in;
      found_ff      <= found_in;
      stolen_ff     <= stolen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_picked_ff <= rsp_picked_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_steals_ff <= rsp_steals_in;
   end

   pcrq_store #(
      .SLOTS     (SLOTS),
      .NUM_TASKS (NUM_TASKS),
      .CW        (CW)
   ) u_store (
      .clock      (clock),
      .ctl        (st_ctl),
      .slot_waddr (slot_waddr),
      .slot_wdata (slot_wdata),
      .slot_raddr (slot_raddr),
      .slot_rdata (slot_rdata),
      .home_waddr (TW'(s_ff.task_id)),
      .home_wdata (tgt_ff),
      .home_raddr (TW'(task_ff)),
      .home_rdata (home_rdata)
   );

   pcrq_mod #(
      .DIV_W (MW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (MW'(cpus)),
      .rem      (mod_rem),
      .done     (mod_done)
   );

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.picked_task = rsp_picked_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.was_stolen  = rsp_stolen_ff;
   assign rsp_if.steal_count = rsp_steals_ff;

`ifndef SYNTH
   a_put_has_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_PUT |-> int'(cnt) < QUEUE_DEPTH)
      else $error("insert into a full queue");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_SH && !(idx_ff < cnt)) |-> cnt != '0)
      else $error("remove from an empty queue");

   a_victim_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEAL |-> int'(vic_ff) < int'(cpus))
      else $error("steal victim out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the done step");
`endif

endmodule
